FILE: src/gcc_pkg.sv
// Shared types and constants for the graph component counter.
`timescale 1ns / 1ps

package gcc_pkg;

	localparam int VIDX_W          = 6;
	localparam int CFG_W           = 7;
	localparam int CNT_W           = 7;
	localparam int MAX_VERTICES_DEF = 64;
	localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;
	localparam logic [CNT_W-1:0] COUNT_SAT    = 7'd127;

	typedef struct packed {
		logic              has_edge;
		logic [VIDX_W-1:0] edge_source;
		logic [VIDX_W-1:0] edge_target;
		logic              both_ways;
		logic              last_edge;
	} edge_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] component_count;
		logic             all_reached;
	} result_item_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic clear;
	} mem_ctl_t;

endpackage

FILE: src/gcc_adj_mem.sv
// Adjacency matrix memory: bit-set row writes, registered row reads, per-row valid bits.
`timescale 1ns / 1ps

module gcc_adj_mem #(
	parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF,
	parameter int VW           = $clog2(MAX_VERTICES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gcc_pkg::mem_ctl_t       ctl,
	input  logic [VW-1:0]           wr_addr,
	input  logic [VW-1:0]           wr_bit,
	input  logic [VW-1:0]           rd_addr,
	output logic [MAX_VERTICES-1:0] rd_data
);
	import gcc_pkg::*;

	logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_ok_q;
	logic [MAX_VERTICES-1:0] rd_q;
	logic                    rd_ok_q;
	logic [MAX_VERTICES-1:0] onehot;

	always_comb begin
		onehot = '0;
		onehot[wr_bit] = 1'b1;
	end

	// A row that is not valid is replaced whole, so stale contents never show.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			if (row_ok_q[wr_addr]) begin
				adj_q[wr_addr][wr_bit] <= 1'b1;
			end else begin
				adj_q[wr_addr] <= onehot;
			end
		end
		if (ctl.rd_en) begin
			rd_q <= adj_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				row_ok_q <= '0;
			end else if (ctl.wr_en) begin
				row_ok_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_ok_q <= row_ok_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

FILE: src/graph_component_counter.sv
// Top level of the graph component counter: edge loading, walk sequencer, result register.
`timescale 1ns / 1ps

// Edges are stored in an adjacency matrix, one item per cycle while the edge channel
// does not stall; an undirected edge between distinct vertices is written twice and
// stalls the channel for its second write. The item marked last starts the walk: for
// each start vertex a pointer sweeps the n live vertices, reading the row of each
// pending vertex, and sweeps again while newly found vertices remain; the single
// row-read port of the matrix sets the pace. The edge channel stalls during the walk.
// The result waits in an output register, and the matrix is cleared by dropping
// per-row valid bits, so new edges are taken at once. vertex_count values of 0 act
// as 1 and values above MAX_VERTICES act as MAX_VERTICES; edges with an endpoint
// outside the live range are dropped.
module graph_component_counter #(
	parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  edge_valid,
	output logic                  edge_stall,
	input  gcc_pkg::edge_item_t   edge_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output gcc_pkg::result_item_t result_item,
	input  logic                  cfg_we,
	input  logic [gcc_pkg::CFG_W-1:0] cfg_data
);
	import gcc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WR2    = 3'd1;
	localparam logic [2:0] ST_START  = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_EXPAND = 3'd4;

	logic [2:0]              state_q;
	logic [CFG_W-1:0]        vcount_q;
	logic [VW-1:0]           src_q, dst_q;
	logic                    last_q;
	logic [CW-1:0]           start_q, ptr_q;
	logic [CNT_W-1:0]        count_q;
	logic                    whole_q;
	logic [MAX_VERTICES-1:0] visited_q, pending_q;
	logic                    res_valid_q;
	result_item_t            res_q;

	logic [CW-1:0]           n_live;
	logic [CW-1:0]           n_last;
	logic [MAX_VERTICES-1:0] vmask;
	logic [MAX_VERTICES-1:0] row;
	logic [MAX_VERTICES-1:0] found;
	logic [VW-1:0]           a_idx, b_idx;
	logic                    accept, edge_ok;
	logic                    res_free;
	logic                    res_load;
	mem_ctl_t                mctl;
	logic [VW-1:0]           wr_addr, wr_bit;

	always_comb begin
		int nv;
		nv = int'(vcount_q);
		if (nv < 1) nv = 1;
		if (nv > MAX_VERTICES) nv = MAX_VERTICES;
		n_live = CW'(nv);
	end

	assign n_last = n_live - CW'(1);

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			vmask[i] = (i < int'(n_live));
		end
	end

	assign accept   = edge_valid && !edge_stall;
	assign a_idx    = VW'(edge_item.edge_source);
	assign b_idx    = VW'(edge_item.edge_target);
	assign edge_ok  = edge_item.has_edge && (int'(edge_item.edge_source) < int'(n_live))
		&& (int'(edge_item.edge_target) < int'(n_live));
	assign res_free = !res_valid_q || !result_stall;
	assign res_load = (state_q == ST_START) && (start_q >= n_live) && res_free;
	assign found    = row & vmask & ~visited_q;

	always_comb begin
		mctl.wr_en = 1'b0;
		mctl.rd_en = 1'b0;
		mctl.clear = 1'b0;
		wr_addr    = a_idx;
		wr_bit     = b_idx;
		unique case (state_q)
			ST_IDLE: begin
				mctl.wr_en = accept && edge_ok;
			end
			ST_WR2: begin
				mctl.wr_en = 1'b1;
				wr_addr    = dst_q;
				wr_bit     = src_q;
			end
			ST_START: begin
				mctl.clear = (start_q >= n_live) && res_free;
			end
			ST_SCAN: begin
				mctl.rd_en = pending_q[ptr_q[VW-1:0]];
			end
			default: begin
			end
		endcase
	end

	gcc_adj_mem #(
		.MAX_VERTICES(MAX_VERTICES),
		.VW(VW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mctl),
		.wr_addr(wr_addr),
		.wr_bit(wr_bit),
		.rd_addr(ptr_q[VW-1:0]),
		.rd_data(row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q  <= a_idx;
			dst_q  <= b_idx;
			last_q <= edge_item.last_edge;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			ptr_q       <= '0;
			count_q     <= '0;
			whole_q     <= 1'b0;
			visited_q   <= '0;
			pending_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_q   <= '0;
						count_q   <= '0;
						visited_q <= '0;
						pending_q <= '0;
						if (edge_ok && edge_item.both_ways && (a_idx != b_idx)) begin
							state_q <= ST_WR2;
						end else if (edge_item.last_edge) begin
							state_q <= ST_START;
						end
					end
				end
				ST_WR2: begin
					state_q <= last_q ? ST_START : ST_IDLE;
				end
				ST_START: begin
					if (start_q >= n_live) begin
						// Hold until the output register is free.
						if (res_free) begin
							state_q <= ST_IDLE;
						end
					end else if (!visited_q[start_q[VW-1:0]]) begin
						if (count_q != COUNT_SAT) begin
							count_q <= count_q + CNT_W'(1);
						end
						visited_q[start_q[VW-1:0]] <= 1'b1;
						pending_q <= MAX_VERTICES'(1) << start_q[VW-1:0];
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						start_q <= start_q + CW'(1);
					end
				end
				ST_SCAN: begin
					if (pending_q[ptr_q[VW-1:0]]) begin
						pending_q[ptr_q[VW-1:0]] <= 1'b0;
						state_q <= ST_EXPAND;
					end else if (ptr_q != n_last) begin
						ptr_q <= ptr_q + CW'(1);
					end else if (pending_q != '0) begin
						ptr_q <= '0;
					end else begin
						if (start_q == '0) begin
							whole_q <= (visited_q == vmask);
						end
						start_q <= start_q + CW'(1);
						state_q <= ST_START;
					end
				end
				ST_EXPAND: begin
					visited_q <= visited_q | found;
					pending_q <= pending_q | found;
					if (ptr_q != n_last) begin
						ptr_q   <= ptr_q + CW'(1);
						state_q <= ST_SCAN;
					end else if ((pending_q | found) != '0) begin
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						if (start_q == '0) begin
							whole_q <= ((visited_q | found) == vmask);
						end
						start_q <= start_q + CW'(1);
						state_q <= ST_START;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.component_count <= count_q;
			res_q.all_reached     <= whole_q;
		end
	end

	assign edge_stall   = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result_item  = res_q;

endmodule

FILE: src/gcc_checker.sv
// Port-level checks for the graph component counter, bound to the top level.
`timescale 1ns / 1ps

module gcc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  edge_valid,
	input logic                  edge_stall,
	input gcc_pkg::edge_item_t   edge_item,
	input logic                  result_valid,
	input logic                  result_stall,
	input gcc_pkg::result_item_t result_item
);
	import gcc_pkg::*;

	// A waiting result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("result item changed while stalled");

	// Every graph needs at least one walk start.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_item.component_count != '0)
		else $error("zero component count");

	// A walk from vertex zero that covers everything leaves no second start.
	a_reach_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.all_reached |-> result_item.component_count == CNT_W'(1))
		else $error("all reached but more than one start");

	// The walk after the last item blocks new edges.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		edge_valid && !edge_stall && edge_item.last_edge |=> edge_stall)
		else $error("edge channel open right after last item");

endmodule

bind graph_component_counter gcc_checker u_gcc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.edge_valid(edge_valid),
	.edge_stall(edge_stall),
	.edge_item(edge_item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_item(result_item)
);

FILE: bench/graph_component_counter_tb.sv
// Self-checking testbench for the graph component counter: edge streams against a scoreboard.
`timescale 1ns / 1ps

module graph_component_counter_tb;
	import gcc_pkg::*;

	localparam int RANDOM_ITEMS  = 1550;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int STALL_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_AT       = 30;
	localparam int REPORT_LIMIT  = 10;

	// Keeps its own adjacency matrix and vertex count, and queues the
	// component count expected for every graph that has been closed.
	class ComponentScoreboard;
		bit [63:0] adjacency [64];
		logic [CFG_W-1:0] vertex_count;
		result_item_t expected_q [$];
		int mismatches;

		function new();
			vertex_count = VCOUNT_RESET;
			mismatches = 0;
			foreach (adjacency[i]) adjacency[i] = '0;
		endfunction

		function int unsigned live_count();
			if (vertex_count == 0) return 1;
			if (vertex_count > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
			return 32'(vertex_count);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Mark everything reachable from start along out-edges.
		function bit [63:0] reach_from(int unsigned start, int unsigned n, bit [63:0] live,
				bit [63:0] seen);
			bit [63:0] frontier;
			bit [63:0] nxt;
			int unsigned v;
			frontier = 64'd1 << start;
			do begin
				seen |= frontier;
				nxt = '0;
				for (v = 0; v < n; v++)
					if (frontier[v]) nxt |= adjacency[v];
				frontier = nxt & live & ~seen;
			end while (frontier != 0);
			return seen;
		endfunction

		function void note_edge(edge_item_t it);
			int unsigned n;
			int unsigned v;
			bit [63:0] live;
			bit [63:0] seen;
			logic [CNT_W-1:0] starts;
			result_item_t want;
			n = live_count();
			if (it.has_edge && it.edge_source < n && it.edge_target < n) begin
				adjacency[it.edge_source][it.edge_target] = 1'b1;
				if (it.both_ways) adjacency[it.edge_target][it.edge_source] = 1'b1;
			end
			if (!it.last_edge) return;
			live = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
			seen = reach_from(0, n, live, '0);
			want.all_reached = ((seen & live) == live);
			seen = '0;
			starts = '0;
			for (v = 0; v < n; v++) begin
				if (!seen[v]) begin
					if (starts != COUNT_SAT) starts++;
					seen = reach_from(v, n, live, seen);
				end
			end
			want.component_count = starts;
			expected_q = {expected_q, want};
			foreach (adjacency[i]) adjacency[i] = '0;
		endfunction

		function void check_result(result_item_t got);
			result_item_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result item: count %0d all_reached %0b",
						got.component_count, got.all_reached);
				return;
			end
			want = expected_q.pop_front();
			if (got.component_count !== want.component_count) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("component_count: expected %0d, got %0d",
						want.component_count, got.component_count);
			end
			if (got.all_reached !== want.all_reached) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("all_reached: expected %0b, got %0b",
						want.all_reached, got.all_reached);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         edge_valid;
	logic         edge_stall;
	edge_item_t   edge_item;
	logic         result_valid;
	logic         result_stall;
	result_item_t result_item;
	logic         cfg_we;
	logic [CFG_W-1:0] cfg_data;

	ComponentScoreboard sb = new();
	bit send_lazy;
	bit recv_lazy;
	int effective_items;

	graph_component_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.edge_valid(edge_valid),
		.edge_stall(edge_stall),
		.edge_item(edge_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic edge_item_t make_item(logic has, logic [VIDX_W-1:0] src,
			logic [VIDX_W-1:0] dst, logic both, logic last);
		edge_item_t it;
		it.has_edge = has;
		it.edge_source = src;
		it.edge_target = dst;
		it.both_ways = both;
		it.last_edge = last;
		return it;
	endfunction

	// Mostly live vertices, now and then any 6-bit index.
	function automatic logic [VIDX_W-1:0] pick_vertex(int unsigned n);
		if ($urandom_range(0, 7) == 0) return VIDX_W'($urandom_range(0, 63));
		return VIDX_W'($urandom_range(0, n - 1));
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic push_item(input edge_item_t it);
		int unsigned gap;
		gap = send_lazy ? $urandom_range(0, 9) : 0;
		effective_items++;
		if (gap != 0) begin
			edge_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		edge_valid <= 1'b1;
		edge_item <= it;
		do @(posedge clk); while (edge_stall);
		sb.note_edge(it);
		@(negedge clk);
	endtask

	// Write only once the block has drained and edge stores have settled.
	task automatic set_vertex_count(input logic [CFG_W-1:0] value);
		edge_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.vertex_count = value;
	endtask

	task automatic send_graph(input bit finish);
		int unsigned n;
		int unsigned k;
		int unsigned i;
		int unsigned a;
		n = sb.live_count();
		if ($urandom_range(0, 3) == 0) begin
			// Spanning tree, sometimes with edges pointing back toward the root.
			for (i = 1; i < n; i++) begin
				a = $urandom_range(0, i - 1);
				if ($urandom_range(0, 3) == 0)
					push_item(make_item(1'b1, VIDX_W'(i), VIDX_W'(a),
						1'($urandom_range(0, 1)), 1'b0));
				else
					push_item(make_item(1'b1, VIDX_W'(a), VIDX_W'(i),
						1'($urandom_range(0, 1)), 1'b0));
			end
		end else begin
			k = $urandom_range(0, (2 * n < 48) ? 2 * n : 48);
			for (i = 0; i < k; i++)
				push_item(make_item($urandom_range(0, 9) != 0, pick_vertex(n),
					pick_vertex(n), 1'($urandom_range(0, 1)), 1'b0));
		end
		if (finish)
			push_item(make_item(1'($urandom_range(0, 1)), pick_vertex(n), pick_vertex(n),
				1'($urandom_range(0, 1)), 1'b1));
	endtask

	// Result side: random hold-off per item, one long hold to back up the block.
	initial begin
		int unsigned gap;
		int checked;
		bit held;
		checked = 0;
		held = 1'b0;
		result_stall <= 1'b1;
		@(negedge clk);
		forever begin
			if (!held && checked == HOLD_AT) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = recv_lazy ? $urandom_range(0, 9) : 0;
			if (gap != 0) begin
				result_stall <= 1'b1;
				do @(posedge clk); while (!result_valid);
				repeat (gap) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result_item);
			checked++;
			@(negedge clk);
		end
	end

	// End the run when nothing moves for too long.
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((edge_valid && !edge_stall) || (result_valid && !result_stall) || !arst_n)
				idle_run = 0;
			else
				idle_run++;
		end
		$display("graph_component_counter test failed");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned graphs;
		int unsigned g;
		logic [CFG_W-1:0] vcount;
		arst_n <= 1'b0;
		edge_valid <= 1'b0;
		edge_item <= '0;
		cfg_we <= 1'b0;
		cfg_data <= VCOUNT_RESET;
		send_lazy = 1'b1;
		recv_lazy = 1'b1;
		effective_items = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset vertex count: empty graph, self loops, one closing edge.
		push_item(make_item(1'b0, 6'd0, 6'd0, 1'b0, 1'b1));
		push_item(make_item(1'b1, 6'd0, 6'd63, 1'b0, 1'b0));
		push_item(make_item(1'b1, 6'd63, 6'd63, 1'b0, 1'b0));
		push_item(make_item(1'b1, 6'd0, 6'd0, 1'b1, 1'b0));
		push_item(make_item(1'b1, 6'd63, 6'd1, 1'b1, 1'b1));
		// Single vertex, edge out of range dropped.
		set_vertex_count(7'd1);
		push_item(make_item(1'b0, 6'd63, 6'd63, 1'b1, 1'b1));
		push_item(make_item(1'b1, 6'd0, 6'd1, 1'b1, 1'b1));
		// Zero acts as one.
		set_vertex_count(7'd0);
		push_item(make_item(1'b1, 6'd63, 6'd0, 1'b0, 1'b1));
		// Full register value acts as the maximum; repeated edges.
		set_vertex_count(7'd127);
		push_item(make_item(1'b1, 6'd0, 6'd1, 1'b1, 1'b0));
		push_item(make_item(1'b1, 6'd0, 6'd1, 1'b1, 1'b0));
		push_item(make_item(1'b1, 6'd1, 6'd0, 1'b0, 1'b0));
		push_item(make_item(1'b1, 6'd63, 6'd62, 1'b0, 1'b0));
		push_item(make_item(1'b0, 6'd0, 6'd0, 1'b0, 1'b1));
		// Edge only into vertex zero: two starts, vertex zero reaches nothing.
		set_vertex_count(7'd2);
		push_item(make_item(1'b1, 6'd1, 6'd0, 1'b0, 1'b1));
		// Lower the count with edges already stored.
		set_vertex_count(7'd64);
		push_item(make_item(1'b1, 6'd0, 6'd40, 1'b1, 1'b0));
		push_item(make_item(1'b1, 6'd1, 6'd2, 1'b1, 1'b0));
		set_vertex_count(7'd4);
		push_item(make_item(1'b1, 6'd3, 6'd40, 1'b1, 1'b0));
		push_item(make_item(1'b1, 6'd0, 6'd3, 1'b0, 1'b1));
		set_vertex_count(7'd65);
		push_item(make_item(1'b1, 6'd0, 6'd1, 1'b1, 1'b1));

		effective_items = 0;
		while (effective_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: vcount = 7'd0;
				1: vcount = 7'd127;
				2: vcount = CFG_W'($urandom_range(65, 127));
				3: vcount = 7'd64;
				4: vcount = 7'd1;
				5, 6: vcount = CFG_W'($urandom_range(1, 64));
				default: vcount = CFG_W'($urandom_range(2, 12));
			endcase
			set_vertex_count(vcount);
			send_lazy = $urandom_range(0, 3) != 0;
			recv_lazy = $urandom_range(0, 3) != 0;
			graphs = $urandom_range(1, 4);
			// Leave the final graph open now and then, so the next count lands mid-graph.
			for (g = 1; g <= graphs; g++)
				send_graph(!(g == graphs && $urandom_range(0, 5) == 0));
		end

		edge_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("graph_component_counter test passed");
		else
			$display("graph_component_counter test failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/gcc_pkg.sv
src/gcc_adj_mem.sv
src/graph_component_counter.sv
src/gcc_checker.sv
bench/graph_component_counter_tb.sv
